FILE: design/outlier_rejecting_triaxis_averager_defines.svh
// Assertion macros for the outlier rejecting three-axis averager.
`ifndef OUTLIER_REJECTING_TRIAXIS_AVERAGER_DEFINES_SVH
`define OUTLIER_REJECTING_TRIAXIS_AVERAGER_DEFINES_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define ORTA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to another in the next cycle.
`define ORTA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define ORTA_ASSERT(label, prop, msg)
`define ORTA_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

FILE: design/orta_pkg.sv
// Shared types, constants and helpers of the outlier rejecting three-axis averager.
package orta_pkg;

  localparam int unsigned SampleBits        = 16;
  localparam int unsigned CfgBits           = 7;
  localparam int unsigned NumAxes           = 3;
  localparam int unsigned MaxAverageDefault = 64;
  localparam int unsigned AverageCountReset = 32;
  localparam int unsigned MinCount          = 2;
  localparam int unsigned SigmaLimit        = 3;
  localparam int unsigned MinAccepts        = 10;

  // Last cycle of the lane test pipeline, counted from zero.
  localparam logic [1:0] CalcLast = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_x;
    logic signed [SampleBits-1:0] sample_y;
    logic signed [SampleBits-1:0] sample_z;
  } sample_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] avg_x;
    logic signed [SampleBits-1:0] avg_y;
    logic signed [SampleBits-1:0] avg_z;
  } avg_t;

  typedef struct packed {
    logic clear;
    logic est_add;
    logic capture;
    logic acc_add;
    logic div_start;
  } lane_ctrl_t;

  typedef struct packed {
    logic ok;
    logic div_done;
  } lane_stat_t;

  // Clamp a written average count into the supported range.
  function automatic int unsigned eff_n(input logic [CfgBits-1:0] value,
                                        input int unsigned max_avg);
    int unsigned v;
    v = 32'(value);
    if (v < MinCount) begin
      return MinCount;
    end
    if (v > max_avg) begin
      return max_avg;
    end
    return v;
  endfunction

endpackage

FILE: design/orta_div.sv
// Restoring divider: signed sum over unsigned count, one quotient bit a cycle.
module orta_div #(
  parameter int unsigned DIVIDEND_W =
    orta_pkg::SampleBits + $clog2(orta_pkg::MaxAverageDefault + 1),
  parameter int unsigned DIVISOR_W  = $clog2(orta_pkg::MaxAverageDefault + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [DIVIDEND_W-1:0]         dividend_i,
  input  logic        [DIVISOR_W-1:0]          divisor_i,
  output logic signed [orta_pkg::SampleBits-1:0] quotient_o,
  output logic                                 done_o
);
  import orta_pkg::*;

  localparam int unsigned MagW = DIVIDEND_W - 1;
  localparam int unsigned CntW = $clog2(MagW + 1);

  logic                  busy_q;
  logic [CntW-1:0]       cnt_q;
  logic                  neg_q;
  logic [MagW-1:0]       quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;
  logic signed [DIVIDEND_W-1:0] dividend_abs;
  logic [SampleBits-1:0] q_mag;

  always_comb begin
    trial        = {rem_q, quo_q[MagW-1]};
    diff         = trial - {1'b0, divisor_i};
    fits         = trial >= {1'b0, divisor_i};
    dividend_abs = dividend_i[DIVIDEND_W-1] ? -dividend_i : dividend_i;
    q_mag        = quo_q[SampleBits-1:0];
    quotient_o   = neg_q ? (~q_mag + 1'b1) : q_mag;
    done_o       = !busy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(MagW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIVIDEND_W-1];
      quo_q <= dividend_abs[MagW-1:0];
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[MagW-2:0], fits};
      rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

endmodule

FILE: design/orta_lane.sv
// One axis lane: running sums, three-stage spread test and the averaging divider.
module orta_lane #(
  parameter int unsigned MAX_AVERAGE = orta_pkg::MaxAverageDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  orta_pkg::lane_ctrl_t                   ctrl_i,
  input  logic [$clog2(MAX_AVERAGE+1)-1:0]       n_i,
  input  logic signed [orta_pkg::SampleBits-1:0] sample_i,
  output orta_pkg::lane_stat_t                   stat_o,
  output logic signed [orta_pkg::SampleBits-1:0] avg_o
);
  import orta_pkg::*;

  localparam int unsigned NW     = $clog2(MAX_AVERAGE + 1);
  localparam int unsigned SumW   = SampleBits + NW;
  localparam int unsigned MagW   = SumW - 1;
  localparam int unsigned SqInW  = 2 * SampleBits;
  localparam int unsigned SqW    = 2 * SampleBits - 2 + NW;
  localparam int unsigned DW     = SampleBits + NW + 1;
  localparam int unsigned DmW    = DW - 1;
  localparam int unsigned Dm2W   = 2 * DmW;
  localparam int unsigned SpW    = 2 * MagW;
  localparam int unsigned N9W    = NW + 4;
  localparam int unsigned CmpW   = 2 * SampleBits + 3 * NW + 2;

  logic signed [SumW-1:0]       sum_q, sum_d;
  logic        [SqW-1:0]        sq_q, sq_d;
  logic signed [SumW-1:0]       acc_q, acc_d, acc_next;
  logic signed [SampleBits-1:0] x_q;
  logic        [SampleBits-1:0] raw_in;
  logic        [SampleBits-1:0] a_mag;
  logic        [SqInW-1:0]      a_sq;
  logic signed [DW-1:0]         xn;
  logic signed [DW-1:0]         d_d, d_q;
  logic signed [DW-1:0]         d_abs;
  logic        [DmW-1:0]        d_mag;
  logic signed [SumW-1:0]       s_abs;
  logic        [MagW-1:0]       s_mag;
  logic        [SpW-1:0]        sm2_d, sm2_q, nq_d, nq_q, spread_d, spread_q;
  logic        [Dm2W-1:0]       dm2_d, dm2_q;
  logic        [NW-1:0]         nm1;
  logic        [N9W-1:0]        n9;
  logic        [CmpW-1:0]       lhs_d, lhs_q, rhs_d, rhs_q;
  logic                         div_done;

  // Running sums: estimation accumulates, acceptance adds passing samples.
  always_comb begin
    raw_in   = sample_i;
    a_mag    = raw_in[SampleBits-1] ? (~raw_in + 1'b1) : raw_in;
    a_sq     = SqInW'(a_mag) * SqInW'(a_mag);
    sum_d    = sum_q;
    sq_d     = sq_q;
    if (ctrl_i.est_add) begin
      sum_d = sum_q + SumW'(sample_i);
      sq_d  = sq_q + SqW'(a_sq);
    end
    acc_next = ctrl_i.acc_add ? (acc_q + SumW'(x_q)) : acc_q;
    acc_d    = acc_next;
    if (ctrl_i.clear) begin
      sum_d = '0;
      sq_d  = '0;
      acc_d = '0;
    end
  end

  // Test pipeline: deviation, squares, scaled comparison.
  always_comb begin
    xn       = DW'(x_q) * DW'($signed({1'b0, n_i}));
    d_d      = xn - DW'(sum_q);
    s_abs    = sum_q[SumW-1] ? -sum_q : sum_q;
    s_mag    = s_abs[MagW-1:0];
    sm2_d    = SpW'(s_mag) * SpW'(s_mag);
    nq_d     = SpW'(n_i) * SpW'(sq_q);

    d_abs    = d_q[DW-1] ? -d_q : d_q;
    d_mag    = d_abs[DmW-1:0];
    dm2_d    = Dm2W'(d_mag) * Dm2W'(d_mag);
    spread_d = nq_q - sm2_q;

    nm1      = n_i - 1'b1;
    n9       = N9W'(n_i) * N9W'(SigmaLimit * SigmaLimit);
    lhs_d    = CmpW'(dm2_q) * CmpW'(nm1);
    rhs_d    = CmpW'(spread_q) * CmpW'(n9);

    stat_o.ok       = lhs_q < rhs_q;
    stat_o.div_done = div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      sq_q  <= '0;
      acc_q <= '0;
    end else begin
      sum_q <= sum_d;
      sq_q  <= sq_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      x_q <= sample_i;
    end
    d_q      <= d_d;
    sm2_q    <= sm2_d;
    nq_q     <= nq_d;
    dm2_q    <= dm2_d;
    spread_q <= spread_d;
    lhs_q    <= lhs_d;
    rhs_q    <= rhs_d;
  end

  orta_div #(
    .DIVIDEND_W (SumW),
    .DIVISOR_W  (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (acc_next),
    .divisor_i  (n_i),
    .quotient_o (avg_o),
    .done_o     (div_done)
  );

endmodule

FILE: design/orta_ctrl.sv
// Sequencer and merge stage: phase, counts, lane verdicts and restart decisions.
module orta_ctrl #(
  parameter int unsigned MAX_AVERAGE = orta_pkg::MaxAverageDefault
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic                                        cfg_we_i,
  input  logic [orta_pkg::CfgBits-1:0]                cfg_data_i,
  input  orta_pkg::lane_stat_t [orta_pkg::NumAxes-1:0] lane_stat_i,
  input  logic                                        out_free_i,
  output orta_pkg::lane_ctrl_t                        lane_ctrl_o,
  output logic [$clog2(MAX_AVERAGE+1)-1:0]            n_o,
  output logic                                        out_load_o
);
  import orta_pkg::*;

  localparam int unsigned NW   = $clog2(MAX_AVERAGE + 1);
  localparam int unsigned CntW = $clog2(MAX_AVERAGE + 2);

  state_e          state_q, state_d;
  logic [1:0]      calc_q, calc_d;
  logic            test_phase_q, test_phase_d;
  logic [CntW-1:0] est_q, est_d;
  logic [CntW-1:0] acc_q, acc_d;
  logic [CntW-1:0] rej_q, rej_d;
  logic [NW-1:0]   n_q, n_d;
  logic [CntW-1:0] n_ext;
  logic [CntW-1:0] est_n, acc_n, rej_n;
  logic            all_ok, all_done;

  assign n_o = n_q;

  always_comb begin
    all_ok   = 1'b1;
    all_done = 1'b1;
    for (int i = 0; i < NumAxes; i++) begin
      all_ok   = all_ok & lane_stat_i[i].ok;
      all_done = all_done & lane_stat_i[i].div_done;
    end
    n_ext = CntW'(n_q);
    est_n = est_q + CntW'(1);
    acc_n = acc_q + CntW'(all_ok);
    rej_n = rej_q + CntW'(!all_ok);

    state_d      = state_q;
    calc_d       = calc_q;
    test_phase_d = test_phase_q;
    est_d        = est_q;
    acc_d        = acc_q;
    rej_d        = rej_q;
    n_d          = n_q;
    lane_ctrl_o  = '0;
    out_load_o   = 1'b0;
    in_ready_o   = (state_q == ST_IDLE) && !cfg_we_i;

    if (cfg_we_i) begin
      // New count: drop everything and start estimating afresh.
      n_d               = NW'(eff_n(cfg_data_i, MAX_AVERAGE));
      test_phase_d      = 1'b0;
      est_d             = '0;
      acc_d             = '0;
      rej_d             = '0;
      lane_ctrl_o.clear = 1'b1;
      state_d           = ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (!test_phase_q) begin
              lane_ctrl_o.est_add = 1'b1;
              est_d               = est_n;
              if (est_n >= n_ext) begin
                test_phase_d = 1'b1;
                acc_d        = '0;
                rej_d        = '0;
              end
            end else begin
              lane_ctrl_o.capture = 1'b1;
              calc_d              = '0;
              state_d             = ST_CALC;
            end
          end
        end
        ST_CALC: begin
          if (calc_q == CalcLast) begin
            lane_ctrl_o.acc_add = all_ok;
            if (acc_n >= n_ext) begin
              lane_ctrl_o.div_start = 1'b1;
              lane_ctrl_o.clear     = 1'b1;
              test_phase_d          = 1'b0;
              est_d                 = '0;
              acc_d                 = '0;
              rej_d                 = '0;
              state_d               = ST_DIV;
            end else if ((rej_n > acc_n && 32'(acc_n) > MinAccepts) || rej_n > n_ext) begin
              lane_ctrl_o.clear = 1'b1;
              test_phase_d      = 1'b0;
              est_d             = '0;
              acc_d             = '0;
              rej_d             = '0;
              state_d           = ST_IDLE;
            end else begin
              acc_d   = acc_n;
              rej_d   = rej_n;
              state_d = ST_IDLE;
            end
          end else begin
            calc_d = calc_q + 2'd1;
          end
        end
        ST_DIV: begin
          if (all_done && out_free_i) begin
            out_load_o = 1'b1;
            state_d    = ST_IDLE;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      calc_q       <= '0;
      test_phase_q <= 1'b0;
      est_q        <= '0;
      acc_q        <= '0;
      rej_q        <= '0;
      n_q          <= NW'(eff_n(CfgBits'(AverageCountReset), MAX_AVERAGE));
    end else begin
      state_q      <= state_d;
      calc_q       <= calc_d;
      test_phase_q <= test_phase_d;
      est_q        <= est_d;
      acc_q        <= acc_d;
      rej_q        <= rej_d;
      n_q          <= n_d;
    end
  end

endmodule

FILE: design/outlier_rejecting_triaxis_averager.sv
// Top level of the outlier rejecting three-axis averager (sigma-clipped mean).
//
// Channel   Handshake                    Payload
// -------   ---------------------------  --------------------------------------
// input     in_valid_i / in_ready_o      sample_i (orta_pkg::sample_t)
// output    out_valid_o / out_ready_i    avg_o (orta_pkg::avg_t)
// config    cfg_we_i (no wait)           cfg_data_i, average count N
//
// An estimation item is added to the running sums. A test item passes three registered
// multiply stages in each axis lane, then the merge step that decides.
// An item that completes the average then runs the SampleBits + NW - 1 steps of
// each lane's restoring divider, followed by the load into the output register.
// Reset (asynchronous, active low) clears all sums and counts and sets N to 32.
// The output register holds a finished item until taken; input items are
// taken meanwhile, and a new result waits in the dividers only if it is still full.

`include "outlier_rejecting_triaxis_averager_defines.svh"

module outlier_rejecting_triaxis_averager #(
  parameter int unsigned MAX_AVERAGE = orta_pkg::MaxAverageDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  orta_pkg::sample_t            sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output orta_pkg::avg_t               avg_o,
  input  logic                         cfg_we_i,
  input  logic [orta_pkg::CfgBits-1:0] cfg_data_i
);
  import orta_pkg::*;

  localparam int unsigned NW = $clog2(MAX_AVERAGE + 1);

  lane_ctrl_t                   lane_ctrl;
  lane_stat_t [NumAxes-1:0]     lane_stat;
  logic [NW-1:0]                n;
  logic                         out_load;
  logic                         out_free;
  logic                         in_fire;
  logic signed [SampleBits-1:0] lane_sample [NumAxes];
  logic signed [SampleBits-1:0] lane_avg    [NumAxes];
  logic                         out_valid_q, out_valid_d;
  avg_t                         avg_q, avg_d;

  // Route each axis of the item to its own lane.
  assign lane_sample[0] = sample_i.sample_x;
  assign lane_sample[1] = sample_i.sample_y;
  assign lane_sample[2] = sample_i.sample_z;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  orta_ctrl #(
    .MAX_AVERAGE (MAX_AVERAGE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .lane_stat_i (lane_stat),
    .out_free_i  (out_free),
    .lane_ctrl_o (lane_ctrl),
    .n_o         (n),
    .out_load_o  (out_load)
  );

  // One lane per axis; all three see the same control and run in lock-step.
  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    orta_lane #(
      .MAX_AVERAGE (MAX_AVERAGE)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .n_i      (n),
      .sample_i (lane_sample[g]),
      .stat_o   (lane_stat[g]),
      .avg_o    (lane_avg[g])
    );
  end

  // Output register: load the averages once the dividers finish, hold until taken.
  always_comb begin
    out_valid_d = out_valid_q;
    avg_d       = avg_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      avg_d.avg_x = lane_avg[0];
      avg_d.avg_y = lane_avg[1];
      avg_d.avg_z = lane_avg[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q <= avg_d;
  end

  assign out_valid_o = out_valid_q;
  assign avg_o       = avg_q;

  // A result never overwrites an item still waiting at the output.
  `ORTA_ASSERT(a_load_into_free_output, out_load |-> out_free, "result loaded over a waiting item")
  // Input acceptance and result loading belong to different sequencer states.
  `ORTA_ASSERT(a_no_load_on_accept, !(in_fire && out_load), "item accepted while loading a result")
  // A count write leaves the block ready for a fresh estimation.
  `ORTA_ASSERT_NEXT(a_ready_after_config, cfg_we_i, in_ready_o || cfg_we_i, "not ready after write")

endmodule
